>>> hdl/scfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scfr_pkg
// Types, constants and decode functions shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package scfr_pkg;

	// widths fixed by the register map and item fields
	localparam int HEADER_W  = 32;
	localparam int CODES_W   = 48;
	localparam int TIMEOUT_W = 16;
	localparam int APB_DW    = 64;
	localparam int APB_AW    = 5;

	// defaults for top level parameters
	localparam int TICK_WIDTH_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

	// register indexes (paddr[4:3])
	localparam logic [1:0] REG_HEADER  = 2'd0;
	localparam logic [1:0] REG_CODES   = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;

	// command kinds
	localparam logic [2:0] CMD_ON     = 3'd0;
	localparam logic [2:0] CMD_OFF    = 3'd1;
	localparam logic [2:0] CMD_PAIR   = 3'd2;
	localparam logic [2:0] CMD_UNPAIR = 3'd3;
	localparam logic [2:0] CMD_COLOR  = 3'd4;
	localparam logic [2:0] CMD_BRIGHT = 3'd5;
	localparam int NUM_CMDS = 6;

	// colour choices
	localparam logic [2:0] COLOR_NONE  = 3'd0;
	localparam logic [2:0] COLOR_TEMP1 = 3'd1;
	localparam logic [2:0] COLOR_TEMP2 = 3'd2;
	localparam logic [2:0] COLOR_TEMP3 = 3'd3;
	localparam logic [2:0] COLOR_BLUE  = 3'd4;
	localparam logic [2:0] COLOR_CYAN  = 3'd5;
	localparam logic [2:0] COLOR_GREEN = 3'd6;

	// request item
	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
	} req_item_t;

	// result item
	typedef struct packed {
		logic       accepted;
		logic       rejected;
		logic       frame_done;
		logic       timed_out;
		logic [2:0] command_kind;
		logic [2:0] color_choice;
		logic [2:0] brightness_level;
	} rsp_item_t;

	// classified request as held in the queue
	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
		logic [3:0] hdr_hit;
		logic       cmd_hit;
		logic [2:0] cmd_kind;
		logic [2:0] level;
	} cls_item_t;

	// total frame length per command
	function automatic logic [3:0] length_of_kind(input logic [2:0] kind);
		logic [3:0] len;
		case (kind)
			CMD_ON:     len = 4'd9;
			CMD_OFF:    len = 4'd8;
			CMD_PAIR:   len = 4'd9;
			CMD_UNPAIR: len = 4'd9;
			CMD_COLOR:  len = 4'd11;
			CMD_BRIGHT: len = 4'd10;
			default:    len = 4'd0;
		endcase
		return len;
	endfunction

	// brightness level from frame byte 7
	function automatic logic [2:0] decode_level(input logic [7:0] v);
		logic [2:0] lvl;
		case (v)
			8'h05:   lvl = 3'd1;
			8'h0A:   lvl = 3'd2;
			8'h19:   lvl = 3'd3;
			8'h32:   lvl = 3'd4;
			8'h4B:   lvl = 3'd5;
			8'h64:   lvl = 3'd6;
			default: lvl = 3'd0;
		endcase
		return lvl;
	endfunction

	// colour choice from frame bytes 8 and 9
	function automatic logic [2:0] decode_color(input logic [7:0] a, input logic [7:0] b);
		logic [2:0] c;
		if (a == 8'hD3 && b == 8'h42)      c = COLOR_TEMP1;
		else if (a == 8'h72 && b == 8'hA5) c = COLOR_TEMP2;
		else if (a == 8'h3F && b == 8'hD1) c = COLOR_TEMP3;
		else if (a == 8'h00 && b == 8'hFF) c = COLOR_BLUE;
		else if (a == 8'h3F && b == 8'hA5) c = COLOR_CYAN;
		else if (a == 8'hFF && b == 8'h00) c = COLOR_GREEN;
		else                               c = COLOR_NONE;
		return c;
	endfunction

endpackage
`default_nettype wire

>>> hdl/scfr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scfr_front
// Accepts requests and classifies each byte against the configured header
// bytes, command codes and brightness table before it enters the queue.
// ----------------------------------------------------------------------------
module scfr_front (
	input  wire                               req_valid,
	output logic                              req_ready,
	input  scfr_pkg::req_item_t               req_data,
	input  wire  [scfr_pkg::HEADER_W-1:0]     header_bytes,
	input  wire  [scfr_pkg::CODES_W-1:0]      command_codes,
	input  wire                               queue_full,
	output logic                              push,
	output scfr_pkg::cls_item_t               push_item
);
	import scfr_pkg::*;

	// handshake into the queue
	assign req_ready = !queue_full;
	assign push      = req_valid && !queue_full;

	// per-position header compare, first command match, level decode
	always_comb begin
		push_item           = '0;
		push_item.action    = req_data.action;
		push_item.data_byte = req_data.data_byte;
		for (int i = 0; i < 4; i++) begin
			push_item.hdr_hit[i] = (req_data.data_byte == header_bytes[HEADER_W-1-8*i -: 8]);
		end
		for (int k = NUM_CMDS - 1; k >= 0; k--) begin
			if (command_codes[8*k +: 8] == req_data.data_byte) begin
				push_item.cmd_hit  = 1'b1;
				push_item.cmd_kind = 3'(k);
			end
		end
		push_item.level = decode_level(req_data.data_byte);
	end

endmodule
`default_nettype wire

>>> hdl/scfr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scfr_queue
// Short queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module scfr_queue #(
	parameter int DEPTH = scfr_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  scfr_pkg::cls_item_t  push_item,
	output logic                 full,
	input  wire                  pop,
	output logic                 head_valid,
	output scfr_pkg::cls_item_t  head_item
);
	import scfr_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cls_item_t         entries_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entries_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_q + PW'(1));
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_q + PW'(1));
			end
			if (push && !pop) begin
				count_q <= CW'(count_q + CW'(1));
			end else if (pop && !push) begin
				count_q <= CW'(count_q - CW'(1));
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/scfr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scfr_back
// Frame state machine: tracks header, command and data bytes, the running
// checksum and the tick timeout, and registers one result per request.
// ----------------------------------------------------------------------------
module scfr_back #(
	parameter int TICK_WIDTH = scfr_pkg::TICK_WIDTH_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               head_valid,
	input  scfr_pkg::cls_item_t               head_item,
	output logic                              pop,
	input  wire  [scfr_pkg::TIMEOUT_W-1:0]    timeout_ticks,
	output logic                              rsp_valid,
	input  wire                               rsp_ready,
	output scfr_pkg::rsp_item_t               rsp_data
);
	import scfr_pkg::*;

	localparam int CMP_W = (TICK_WIDTH > TIMEOUT_W) ? TICK_WIDTH : TIMEOUT_W;

	typedef enum logic [5:0] {
		PH_HDR0 = 6'b000001,
		PH_HDR1 = 6'b000010,
		PH_HDR2 = 6'b000100,
		PH_HDR3 = 6'b001000,
		PH_CMD  = 6'b010000,
		PH_DATA = 6'b100000
	} phase_t;

	phase_t                phase_q, phase_d;
	logic [3:0]            cnt_q, cnt_d;
	logic [3:0]            len_q, len_d;
	logic [7:0]            xor_q, xor_d;
	logic [2:0]            kind_q, kind_d;
	logic [TICK_WIDTH-1:0] tick_q, tick_d;
	logic                  armed_q, armed_d;
	logic [2:0]            lvl7_q;
	logic [7:0]            byte8_q;
	logic [7:0]            byte9_q;
	logic                  out_valid_q;
	rsp_item_t             rsp_q, rsp_d;

	logic                  ok;
	logic                  finished;
	logic                  clear;
	logic [3:0]            cnt_inc;
	logic [TICK_WIDTH-1:0] tick_inc;

	// take the next request whenever the result register can be refilled
	assign pop       = head_valid && (!out_valid_q || rsp_ready);
	assign rsp_valid = out_valid_q;
	assign rsp_data  = rsp_q;

	assign cnt_inc  = 4'(cnt_q + 4'd1);
	assign tick_inc = (tick_q != {TICK_WIDTH{1'b1}}) ? TICK_WIDTH'(tick_q + TICK_WIDTH'(1)) : tick_q;

	// next state and result for the request at the head of the queue
	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		len_d    = len_q;
		xor_d    = xor_q;
		kind_d   = kind_q;
		tick_d   = tick_q;
		armed_d  = armed_q;
		rsp_d    = '0;
		ok       = 1'b0;
		finished = 1'b0;
		clear    = 1'b0;
		if (head_item.action) begin
			// timer tick
			if (armed_q) begin
				tick_d = tick_inc;
				if (CMP_W'(tick_inc) >= CMP_W'(timeout_ticks)) begin
					clear           = 1'b1;
					rsp_d.timed_out = 1'b1;
				end
			end
		end else begin
			case (phase_q)
				PH_HDR0: begin
					ok      = head_item.hdr_hit[0];
					phase_d = PH_HDR1;
					cnt_d   = cnt_inc;
				end
				PH_HDR1: begin
					ok      = head_item.hdr_hit[1];
					phase_d = PH_HDR2;
					cnt_d   = cnt_inc;
				end
				PH_HDR2: begin
					ok      = head_item.hdr_hit[2];
					phase_d = PH_HDR3;
					cnt_d   = cnt_inc;
				end
				PH_HDR3: begin
					ok      = head_item.hdr_hit[3];
					phase_d = PH_CMD;
					cnt_d   = cnt_inc;
				end
				PH_CMD: begin
					ok      = head_item.cmd_hit;
					kind_d  = head_item.cmd_kind;
					len_d   = length_of_kind(head_item.cmd_kind);
					phase_d = PH_DATA;
					cnt_d   = cnt_inc;
				end
				PH_DATA: begin
					cnt_d = cnt_inc;
					if (cnt_inc >= len_q) begin
						ok       = (xor_q == head_item.data_byte);
						finished = ok;
					end else begin
						ok = 1'b1;
					end
				end
				default: begin
					ok = 1'b0;
				end
			endcase
			if (ok) begin
				rsp_d.accepted = 1'b1;
				xor_d          = xor_q ^ head_item.data_byte;
				if (finished) begin
					rsp_d.frame_done   = 1'b1;
					rsp_d.command_kind = kind_q;
					if (kind_q == CMD_COLOR) begin
						rsp_d.color_choice = decode_color(byte8_q, byte9_q);
					end else if (kind_q == CMD_BRIGHT) begin
						rsp_d.brightness_level = lvl7_q;
					end
					clear = 1'b1;
				end else begin
					armed_d = 1'b1;
					tick_d  = '0;
				end
			end else begin
				rsp_d.rejected = 1'b1;
				clear          = 1'b1;
			end
		end
		if (clear) begin
			phase_d = PH_HDR0;
			cnt_d   = '0;
			len_d   = '0;
			xor_d   = '0;
			kind_d  = '0;
			tick_d  = '0;
			armed_d = 1'b0;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR0;
			cnt_q       <= '0;
			len_q       <= '0;
			xor_q       <= '0;
			kind_q      <= '0;
			tick_q      <= '0;
			armed_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_d;
				cnt_q       <= cnt_d;
				len_q       <= len_d;
				xor_q       <= xor_d;
				kind_q      <= kind_d;
				tick_q      <= tick_d;
				armed_q     <= armed_d;
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload bytes and result register
	always_ff @(posedge clk) begin
		if (pop) begin
			rsp_q <= rsp_d;
			if (!head_item.action && ok) begin
				if (cnt_q == 4'd7) lvl7_q  <= head_item.level;
				if (cnt_q == 4'd8) byte8_q <= head_item.data_byte;
				if (cnt_q == 4'd9) byte9_q <= head_item.data_byte;
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/serial_command_frame_receiver.sv
`default_nettype none
// path: an accepted request is queued, and its result is registered when popped
// throughput: one request per cycle, sustained while results are taken; the back end retires one
//   queued request per cycle whenever its result register is free
// reset: arst_n clears frame state, queue pointers and the result valid;
//   registers return to header 0, codes 0, timeout 1000; no clearing pass
// ----------------------------------------------------------------------------
// serial_command_frame_receiver
// Frame receiver top level: register port, request classifier, queue and
// frame state machine.
// ----------------------------------------------------------------------------
module serial_command_frame_receiver #(
	parameter int TICK_WIDTH  = scfr_pkg::TICK_WIDTH_DEF,
	parameter int QUEUE_DEPTH = scfr_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             req_valid,
	output logic                            req_ready,
	input  scfr_pkg::req_item_t             req_data,
	output logic                            rsp_valid,
	input  wire                             rsp_ready,
	output scfr_pkg::rsp_item_t             rsp_data,
	input  wire                             psel,
	input  wire                             penable,
	input  wire                             pwrite,
	input  wire  [scfr_pkg::APB_AW-1:0]     paddr,
	input  wire  [scfr_pkg::APB_DW-1:0]     pwdata,
	output logic [scfr_pkg::APB_DW-1:0]     prdata,
	output logic                            pready
);
	import scfr_pkg::*;

	logic [HEADER_W-1:0]  header_q;
	logic [CODES_W-1:0]   codes_q;
	logic [TIMEOUT_W-1:0] timeout_q;
	logic [1:0]           reg_idx;
	logic                 wr_en;

	logic                 queue_full;
	logic                 push;
	cls_item_t            push_item;
	logic                 pop;
	logic                 head_valid;
	cls_item_t            head_item;

	// register port
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q  <= '0;
			codes_q   <= '0;
			timeout_q <= TIMEOUT_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_HEADER:  header_q  <= pwdata[HEADER_W-1:0];
				REG_CODES:   codes_q   <= pwdata[CODES_W-1:0];
				REG_TIMEOUT: timeout_q <= pwdata[TIMEOUT_W-1:0];
				default:     ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (reg_idx)
			REG_HEADER:  prdata = APB_DW'(header_q);
			REG_CODES:   prdata = APB_DW'(codes_q);
			REG_TIMEOUT: prdata = APB_DW'(timeout_q);
			default:     prdata = '0;
		endcase
	end

	// request classifier
	scfr_front u_front (
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req_data      (req_data),
		.header_bytes  (header_q),
		.command_codes (codes_q),
		.queue_full    (queue_full),
		.push          (push),
		.push_item     (push_item)
	);

	// queue between classifier and frame machine
	scfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// frame machine and result register
	scfr_back #(
		.TICK_WIDTH (TICK_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.pop           (pop),
		.timeout_ticks (timeout_q),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.rsp_data      (rsp_data)
	);

endmodule
`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial command frame receiver. Bytes and timer
// ticks are pushed through the request channel with random gaps, while the
// result channel stalls at random. A scoreboard tracks the frame state
// alongside the block and compares every report field by field. Register
// settings change between phases once the block has drained.
// ----------------------------------------------------------------------------
module tb;
	import scfr_pkg::*;

	localparam int TICK_W = TICK_WIDTH_DEF;

	// frame length per command kind, indexed by kind
	localparam logic [NUM_CMDS-1:0][3:0] FRAME_LEN =
		{4'd10, 4'd11, 4'd9, 4'd9, 4'd8, 4'd9};

	// byte 7 values that map to a brightness level
	localparam logic [5:0][7:0] LEVEL_BYTES =
		{8'h05, 8'h0A, 8'h19, 8'h32, 8'h4B, 8'h64};

	// byte 8 and 9 pairs that map to a colour choice
	localparam logic [5:0][15:0] COLOR_PAIRS =
		{16'hD342, 16'h72A5, 16'h3FD1, 16'h00FF, 16'h3FA5, 16'hFF00};

	typedef enum logic [2:0] {
		PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_CMD, PH_DATA
	} rx_phase_t;

	// tracks the frame state and holds the reports still to come
	class frame_scoreboard;
		logic [HEADER_W-1:0]  hdr;
		logic [CODES_W-1:0]   codes;
		logic [TIMEOUT_W-1:0] limit_ticks;
		rx_phase_t            phase;
		logic [3:0]           count;
		logic [3:0]           frame_len;
		logic [7:0]           xsum;
		logic [2:0]           kind;
		logic [7:0]           pay [3];
		logic [TICK_W-1:0]    ticks;
		logic                 armed;
		rsp_item_t            pending_reports [$];
		int                   errors;
		int                   reports;
		int                   frames;
		int                   rejects;
		int                   timeouts;

		function new();
			hdr = '0;
			codes = '0;
			limit_ticks = TIMEOUT_RESET;
			errors = 0;
			reports = 0;
			frames = 0;
			rejects = 0;
			timeouts = 0;
			drop_frame();
		endfunction

		// back to idle with the timeout disarmed
		function void drop_frame();
			phase = PH_HDR0;
			count = '0;
			frame_len = '0;
			xsum = '0;
			kind = '0;
			pay[0] = '0;
			pay[1] = '0;
			pay[2] = '0;
			ticks = '0;
			armed = 1'b0;
		endfunction

		function void set_register(logic [1:0] idx, logic [APB_DW-1:0] val);
			case (idx)
				REG_HEADER:  hdr = val[HEADER_W-1:0];
				REG_CODES:   codes = val[CODES_W-1:0];
				REG_TIMEOUT: limit_ticks = val[TIMEOUT_W-1:0];
				default:     ;
			endcase
		endfunction

		// next report for one request, advancing the frame state
		function rsp_item_t predict_report(req_item_t it);
			rsp_item_t  r;
			logic       ok;
			logic       fin;
			logic [3:0] pos;
			logic [7:0] b;
			logic [7:0] want;
			r = '0;
			ok = 1'b0;
			fin = 1'b0;
			pos = count;
			b = it.data_byte;
			if (it.action) begin
				// tick: only counts while a frame is partial
				if (armed) begin
					if (ticks != {TICK_W{1'b1}})
						ticks = ticks + 1'b1;
					if (ticks >= limit_ticks) begin
						drop_frame();
						r.timed_out = 1'b1;
					end
				end
			end else begin
				if (phase < PH_CMD) begin
					want = hdr[8 * (3 - int'(phase)) +: 8];
					if (b == want) begin
						ok = 1'b1;
						phase = rx_phase_t'(phase + 1);
						count = count + 4'd1;
					end
				end else if (phase == PH_CMD) begin
					// first matching code wins
					for (int k = 0; k < NUM_CMDS; k++) begin
						if (!ok && codes[8 * k +: 8] == b) begin
							ok = 1'b1;
							kind = 3'(k);
							frame_len = FRAME_LEN[k];
							phase = PH_DATA;
							count = count + 4'd1;
						end
					end
				end else begin
					ok = 1'b1;
					count = count + 4'd1;
					if (count >= frame_len) begin
						if (xsum != b)
							ok = 1'b0;
						else
							fin = 1'b1;
					end
				end
				if (ok) begin
					r.accepted = 1'b1;
					if (pos >= 4'd7 && pos <= 4'd9)
						pay[pos - 4'd7] = b;
					xsum = xsum ^ b;
					if (fin) begin
						r.frame_done = 1'b1;
						r.command_kind = kind;
						if (kind == CMD_COLOR) begin
							if (pay[1] == 8'hD3 && pay[2] == 8'h42)      r.color_choice = COLOR_TEMP1;
							else if (pay[1] == 8'h72 && pay[2] == 8'hA5) r.color_choice = COLOR_TEMP2;
							else if (pay[1] == 8'h3F && pay[2] == 8'hD1) r.color_choice = COLOR_TEMP3;
							else if (pay[1] == 8'h00 && pay[2] == 8'hFF) r.color_choice = COLOR_BLUE;
							else if (pay[1] == 8'h3F && pay[2] == 8'hA5) r.color_choice = COLOR_CYAN;
							else if (pay[1] == 8'hFF && pay[2] == 8'h00) r.color_choice = COLOR_GREEN;
							else                                         r.color_choice = COLOR_NONE;
						end else if (kind == CMD_BRIGHT) begin
							case (pay[0])
								8'h05:   r.brightness_level = 3'd1;
								8'h0A:   r.brightness_level = 3'd2;
								8'h19:   r.brightness_level = 3'd3;
								8'h32:   r.brightness_level = 3'd4;
								8'h4B:   r.brightness_level = 3'd5;
								8'h64:   r.brightness_level = 3'd6;
								default: r.brightness_level = 3'd0;
							endcase
						end
						drop_frame();
					end else begin
						armed = 1'b1;
						ticks = '0;
					end
				end else begin
					r.rejected = 1'b1;
					drop_frame();
				end
			end
			return r;
		endfunction

		// returns 1 when the request did more than get ignored
		function bit note_request(req_item_t it);
			rsp_item_t r;
			r = predict_report(it);
			pending_reports.push_back(r);
			return r != '0;
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_response(rsp_item_t got);
			rsp_item_t want;
			if (pending_reports.size() == 0) begin
				errors++;
				$display("%0t: report with none expected, expected none actual %h",
					$time, got);
				return;
			end
			want = pending_reports.pop_front();
			reports++;
			frames += want.frame_done;
			rejects += want.rejected;
			timeouts += want.timed_out;
			compare_field("accepted", want.accepted, got.accepted);
			compare_field("rejected", want.rejected, got.rejected);
			compare_field("frame_done", want.frame_done, got.frame_done);
			compare_field("timed_out", want.timed_out, got.timed_out);
			compare_field("command_kind", want.command_kind, got.command_kind);
			compare_field("color_choice", want.color_choice, got.color_choice);
			compare_field("brightness_level", want.brightness_level, got.brightness_level);
		endfunction

		function int pending();
			return pending_reports.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	req_item_t           req_data = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	rsp_item_t           rsp_data;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	frame_scoreboard sb;
	int              live_items = 0;
	int              settings = 0;
	bit              tx_quiet = 1'b0;
	bit              rx_quiet = 1'b0;

	serial_command_frame_receiver i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// register write: setup phase, access phase, then back to idle
	task automatic apb_write(input logic [1:0] idx, input logic [APB_DW-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(idx, val);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// one request with a random gap ahead of it
	task automatic send_request(input logic act, input logic [7:0] b);
		int        gap;
		req_item_t it;
		gap = tx_quiet ? 0 : $urandom_range(0, 7);
		it.action = act;
		it.data_byte = b;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= it;
		do @(posedge clk); while (!req_ready);
		if (sb.note_request(it))
			live_items++;
	endtask

	// frame built from the current settings, possibly cut short or corrupted
	task automatic send_frame(input logic [2:0] kind, input logic [7:0] b7,
		input logic [7:0] b8, input logic [7:0] b9, input bit bad_sum,
		input int cut, input bit tick_noise);
		logic [7:0] frame [11];
		logic [7:0] sum;
		int         len;
		len = FRAME_LEN[kind];
		sum = '0;
		for (int i = 0; i < len - 1; i++) begin
			if (i < 4)       frame[i] = sb.hdr[8 * (3 - i) +: 8];
			else if (i == 4) frame[i] = sb.codes[8 * kind +: 8];
			else if (i == 7) frame[i] = b7;
			else if (i == 8) frame[i] = b8;
			else if (i == 9) frame[i] = b9;
			else             frame[i] = 8'($urandom_range(0, 255));
			sum = sum ^ frame[i];
		end
		frame[len - 1] = bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum;
		for (int i = 0; i < cut; i++) begin
			if (tick_noise && $urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 3))
					send_request(1'b1, 8'($urandom_range(0, 255)));
			send_request(1'b0, frame[i]);
		end
	endtask

	// wait until every report is back
	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic configure(input logic [HEADER_W-1:0] h, input logic [CODES_W-1:0] c,
		input logic [TIMEOUT_W-1:0] t);
		drain();
		apb_write(REG_HEADER, APB_DW'(h));
		apb_write(REG_CODES, APB_DW'(c));
		apb_write(REG_TIMEOUT, APB_DW'(t));
		settings++;
	endtask

	// result side with random stalls
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_quiet = !rx_quiet;
			stall = rx_quiet ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			sb.check_response(rsp_data);
		end
	end

	// stimulus
	initial begin
		logic [2:0]           kind;
		logic [7:0]           b7;
		logic [15:0]          pair;
		int                   cut;
		int                   target;
		logic [HEADER_W-1:0]  hdr_val;
		logic [CODES_W-1:0]   codes_val;
		logic [TIMEOUT_W-1:0] tmo_val;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: distinct codes, short timeout
		configure(32'hA55A3CC3, {8'h60, 8'h50, 8'h40, 8'h30, 8'h20, 8'h10}, 16'd3);
		send_request(1'b1, 8'hFF);
		send_request(1'b0, 8'h00);
		send_request(1'b0, 8'hA5);
		repeat (3) send_request(1'b1, 8'h00);
		send_frame(CMD_BRIGHT, 8'h64, 8'h00, 8'h00, 1'b0, FRAME_LEN[CMD_BRIGHT], 1'b0);
		send_frame(CMD_COLOR, 8'h00, 8'hFF, 8'h00, 1'b0, FRAME_LEN[CMD_COLOR], 1'b0);

		// random phases, each under its own register setting
		for (int p = 0; p < 6; p++) begin
			hdr_val = $urandom();
			codes_val = {16'($urandom_range(0, 65535)), 32'($urandom())};
			case (p)
				0: begin
					hdr_val = '0;
					tmo_val = 16'd0;
				end
				1: begin
					hdr_val = '1;
					codes_val = {8'hFF, 8'h00, 32'($urandom())};
					tmo_val = 16'd1;
				end
				2: begin
					// duplicate codes everywhere
					codes_val = {6{8'($urandom_range(0, 255))}};
					tmo_val = 16'hFFFF;
				end
				3: tmo_val = 16'd2;
				4: tmo_val = 16'd7;
				default: tmo_val = 16'($urandom_range(3, 40));
			endcase
			configure(hdr_val, codes_val, tmo_val);
			target = live_items + 135;
			while (live_items < target) begin
				tx_quiet = ($urandom_range(0, 4) == 0);
				if ($urandom_range(0, 9) < 7) begin
					kind = 3'($urandom_range(0, NUM_CMDS - 1));
					b7 = $urandom_range(0, 1) ? LEVEL_BYTES[$urandom_range(0, 5)]
						: 8'($urandom_range(0, 255));
					pair = $urandom_range(0, 1) ? COLOR_PAIRS[$urandom_range(0, 5)]
						: 16'($urandom_range(0, 65535));
					cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, FRAME_LEN[kind] - 1)
						: FRAME_LEN[kind];
					send_frame(kind, b7, pair[15:8], pair[7:0], $urandom_range(0, 7) == 0,
						cut, 1'b1);
				end else begin
					repeat ($urandom_range(1, 4))
						send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
				end
			end
		end

		// drain and report
		drain();
		repeat (10) @(posedge clk);
		$display("%0d reports checked under %0d register settings", sb.reports, settings);
		$display("%0d frames completed, %0d bytes rejected, %0d timeouts",
			sb.frames, sb.rejects, sb.timeouts);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog
	initial begin
		#3000000;
		$display("run did not finish in time");
		$display("Mismatches found");
		$finish;
	end

endmodule
